### rtl/timer_queue_scheduler_assert.svh
// assertion macros used by the checker file
`ifndef TIMER_QUEUE_SCHEDULER_ASSERT_SVH
`define TIMER_QUEUE_SCHEDULER_ASSERT_SVH

// property that must hold in the same cycle
`define TQS_ASSERT_NOW(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TQS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/tqs_pkg.sv
// ---------------------------------------------------------------------------
// tqs_pkg
// sizes, codes and control structs of the timer queue scheduler
// ---------------------------------------------------------------------------
package tqs_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int TIME_BITS   = 32;
  localparam int ID_BITS     = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int AMOUNT_W    = 24;
  localparam int TARGET_W    = 16;
  localparam int OUT_ID_W    = 16;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ONESHOT  = 2'd1,
    CMD_PERIODIC = 2'd2,
    CMD_CANCEL   = 2'd3
  } tqs_cmd_e;

  typedef enum logic [2:0] {
    EV_SCHEDULED    = 3'd0,
    EV_BAD_INTERVAL = 3'd1,
    EV_FULL         = 3'd2,
    EV_CANCELLED    = 3'd3,
    EV_NOT_FOUND    = 3'd4,
    EV_EXPIRED      = 3'd5
  } tqs_event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_CSCAN,
    ST_CDONE,
    ST_MARK,
    ST_SELECT,
    ST_FIRE
  } tqs_state_e;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic idx_clr;
    logic idx_inc;
    logic mark;
    logic sel_scan;
    logic cscan;
    logic clr_best;
    logic sched_emit;
    logic cancel_emit;
    logic fire;
  } tqs_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic hit;
    logic found;
    logic out_free;
    logic fire_last;
  } tqs_sts_t;

endpackage

### rtl/tqs_if.sv
// ---------------------------------------------------------------------------
// tqs_in_if / tqs_out_if
// valid/ready channels carrying command words and result words
// ---------------------------------------------------------------------------
interface tqs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [23:0] period_or_delay;
  logic [15:0] target_id;

  modport source (output valid, command, period_or_delay, target_id, input ready);
  modport sink   (input valid, command, period_or_delay, target_id, output ready);
endinterface

interface tqs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [15:0] timer_id;
  logic        last;

  modport source (output valid, event_kind, timer_id, last, input ready);
  modport sink   (input valid, event_kind, timer_id, last, output ready);
endinterface

### rtl/tqs_ctrl.sv
// ---------------------------------------------------------------------------
// tqs_ctrl
// sequencer for schedule, cancel scan and tick mark/select/fire passes
// ---------------------------------------------------------------------------
module tqs_ctrl import tqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_command_i,
  output logic       in_ready_o,
  input  tqs_sts_t   sts_i,
  output tqs_ctl_t   ctl_o
);

  tqs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.cap     = 1'b1;
          ctl_o.idx_clr = 1'b1;
          case (tqs_cmd_e'(in_command_i))
            CMD_TICK:   state_d = ST_MARK;
            CMD_CANCEL: state_d = ST_CSCAN;
            default:    state_d = ST_SCHED;
          endcase
        end
      end
      ST_SCHED: begin
        if (sts_i.out_free) begin
          ctl_o.sched_emit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_CSCAN: begin
        ctl_o.cscan = 1'b1;
        if (sts_i.hit || sts_i.idx_last) begin
          state_d = ST_CDONE;
        end else begin
          ctl_o.idx_inc = 1'b1;
        end
      end
      ST_CDONE: begin
        if (sts_i.out_free) begin
          ctl_o.cancel_emit = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_MARK: begin
        ctl_o.mark = 1'b1;
        if (sts_i.idx_last) begin
          ctl_o.idx_clr  = 1'b1;
          ctl_o.clr_best = 1'b1;
          state_d        = ST_SELECT;
        end else begin
          ctl_o.idx_inc = 1'b1;
        end
      end
      ST_SELECT: begin
        ctl_o.sel_scan = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_FIRE;
        end else begin
          ctl_o.idx_inc = 1'b1;
        end
      end
      ST_FIRE: begin
        if (!sts_i.found) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          ctl_o.fire = 1'b1;
          if (sts_i.fire_last) begin
            state_d = ST_IDLE;
          end else begin
            ctl_o.idx_clr  = 1'b1;
            ctl_o.clr_best = 1'b1;
            state_d        = ST_SELECT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/tqs_datapath.sv
// ---------------------------------------------------------------------------
// tqs_datapath
// slot table, clock, id counter, scan unit and result register
// ---------------------------------------------------------------------------
module tqs_datapath import tqs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tqs_ctl_t            ctl_i,
  output tqs_sts_t            sts_o,
  input  logic [1:0]          in_command_i,
  input  logic [AMOUNT_W-1:0] in_amount_i,
  input  logic [TARGET_W-1:0] in_target_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [2:0]          out_kind_o,
  output logic [OUT_ID_W-1:0] out_id_o,
  output logic                out_last_o
);

  // latched command word
  logic [1:0]          cmd_q;
  logic [AMOUNT_W-1:0] amount_q;
  logic [TARGET_W-1:0] target_q;

  // architectural state
  logic [TIME_BITS-1:0]   now_q;
  logic [ID_BITS-1:0]     next_id_q;
  logic [TIMER_SLOTS-1:0] valid_q;
  logic [TIMER_SLOTS-1:0] due_q;
  logic [TIME_BITS-1:0]   exp_q [TIMER_SLOTS];
  logic [AMOUNT_W-1:0]    ivl_q [TIMER_SLOTS];
  logic                   per_q [TIMER_SLOTS];
  logic [ID_BITS-1:0]     id_q  [TIMER_SLOTS];

  // scan state
  logic [SLOT_W-1:0]    idx_q;
  logic                 found_q;
  logic [SLOT_W-1:0]    bidx_q;
  logic [TIME_BITS-1:0] bover_q;
  logic [ID_BITS-1:0]   bid_q;
  logic [TIME_BITS-1:0] bexp_q;
  logic                 bper_q;

  // result register
  logic                ov_q;
  logic [2:0]          okind_q;
  logic [OUT_ID_W-1:0] oid_q;
  logic                olast_q;

  logic [TIME_BITS-1:0]   rd_exp;
  logic [ID_BITS-1:0]     rd_id;
  logic [TIME_BITS-1:0]   over;
  logic                   rd_due;
  logic                   hit;
  logic                   better;
  logic                   free_any;
  logic [SLOT_W-1:0]      free_idx;
  logic [TIMER_SLOTS-1:0] bsel;
  logic                   out_free;

  // read at the scan index
  assign rd_exp = exp_q[idx_q];
  assign rd_id  = id_q[idx_q];
  assign over   = now_q - rd_exp;
  assign rd_due = valid_q[idx_q] && !over[TIME_BITS-1];
  assign hit    = valid_q[idx_q] && (32'(rd_id) == 32'(target_q));
  assign better = due_q[idx_q] &&
                  (!found_q || (over > bover_q) || ((over == bover_q) && (rd_id < bid_q)));

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(s);
      end
    end
  end

  assign bsel     = TIMER_SLOTS'(1) << bidx_q;
  assign out_free = !ov_q || out_ready_i;

  assign sts_o.idx_last  = (idx_q == SLOT_W'(TIMER_SLOTS - 1));
  assign sts_o.hit       = hit;
  assign sts_o.found     = found_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.fire_last = ((due_q & ~bsel) == '0);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= '0;
      next_id_q <= '0;
      valid_q   <= '0;
      due_q     <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (ctl_i.idx_clr) begin
        idx_q <= '0;
      end else if (ctl_i.idx_inc) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (ctl_i.cap || ctl_i.clr_best) begin
        found_q <= 1'b0;
      end else if ((ctl_i.cscan && hit) || (ctl_i.sel_scan && better)) begin
        found_q <= 1'b1;
      end
      if (ctl_i.cap) begin
        due_q <= '0;
        if (tqs_cmd_e'(in_command_i) == CMD_TICK) begin
          now_q <= now_q + TIME_BITS'(1);
        end
      end
      if (ctl_i.mark) begin
        due_q[idx_q] <= rd_due;
      end
      // schedule result
      if (ctl_i.sched_emit) begin
        ov_q    <= 1'b1;
        olast_q <= 1'b1;
        oid_q   <= '0;
        if ((tqs_cmd_e'(cmd_q) == CMD_PERIODIC) && (amount_q == '0)) begin
          okind_q <= EV_BAD_INTERVAL;
        end else if (free_any) begin
          okind_q           <= EV_SCHEDULED;
          oid_q             <= OUT_ID_W'(next_id_q);
          valid_q[free_idx] <= 1'b1;
          next_id_q         <= next_id_q + ID_BITS'(1);
        end else begin
          okind_q <= EV_FULL;
        end
      end
      // cancel result
      if (ctl_i.cancel_emit) begin
        ov_q    <= 1'b1;
        olast_q <= 1'b1;
        oid_q   <= OUT_ID_W'(target_q);
        if (found_q) begin
          okind_q         <= EV_CANCELLED;
          valid_q[bidx_q] <= 1'b0;
        end else begin
          okind_q <= EV_NOT_FOUND;
        end
      end
      // expiry result, free one-shot
      if (ctl_i.fire) begin
        ov_q          <= 1'b1;
        olast_q       <= sts_o.fire_last;
        okind_q       <= EV_EXPIRED;
        oid_q         <= OUT_ID_W'(bid_q);
        due_q[bidx_q] <= 1'b0;
        if (!bper_q) begin
          valid_q[bidx_q] <= 1'b0;
        end
      end
    end
  end

  // payload: command latch, slot table, best candidate
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q    <= in_command_i;
      amount_q <= in_amount_i;
      target_q <= in_target_i;
    end
    if (ctl_i.cscan && hit) begin
      bidx_q <= idx_q;
    end
    if (ctl_i.sel_scan && better) begin
      bidx_q  <= idx_q;
      bover_q <= over;
      bid_q   <= rd_id;
      bexp_q  <= rd_exp + TIME_BITS'(ivl_q[idx_q]);
      bper_q  <= per_q[idx_q];
    end
    if (ctl_i.sched_emit && free_any &&
        !((tqs_cmd_e'(cmd_q) == CMD_PERIODIC) && (amount_q == '0))) begin
      exp_q[free_idx] <= now_q + TIME_BITS'(amount_q);
      ivl_q[free_idx] <= (tqs_cmd_e'(cmd_q) == CMD_PERIODIC) ? amount_q : '0;
      per_q[free_idx] <= (tqs_cmd_e'(cmd_q) == CMD_PERIODIC);
      id_q[free_idx]  <= next_id_q;
    end
    if (ctl_i.fire && bper_q) begin
      exp_q[bidx_q] <= bexp_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_id_o    = oid_q;
  assign out_last_o  = olast_q;

endmodule

### rtl/timer_queue_scheduler.sv
// ---------------------------------------------------------------------------
// timer_queue_scheduler
// timer table with tick clock, one-shot and periodic timers, cancel by id
// ---------------------------------------------------------------------------
// One command word is taken at a time. A schedule runs the SCHED step, a
// cancel scans the ids (the scan stops at the first match) and then emits
// its result. A tick runs one marking pass over all slots, then one selection
// pass over all slots per expired timer, each followed by a fire step; a
// quiet tick ends after one selection pass. The scans read the slot table
// one slot at a time. A full result register stalls the block until the
// word is taken.
module timer_queue_scheduler import tqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tqs_in_if.sink     in_i,
  tqs_out_if.source  out_o
);

  tqs_ctl_t ctl;
  tqs_sts_t sts;

  // sequencer
  tqs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .sts_i        (sts),
    .ctl_o        (ctl)
  );

  // slot table and result register
  tqs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .in_command_i (in_i.command),
    .in_amount_i  (in_i.period_or_delay),
    .in_target_i  (in_i.target_id),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_kind_o   (out_o.event_kind),
    .out_id_o     (out_o.timer_id),
    .out_last_o   (out_o.last)
  );

endmodule

### rtl/tqs_checker.sv
// ---------------------------------------------------------------------------
// tqs_checker
// port-level checks of the timer queue scheduler
// ---------------------------------------------------------------------------
`include "timer_queue_scheduler_assert.svh"

module tqs_checker import tqs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_kind_i,
  input logic        out_last_i
);

  // stalled word stays offered
  `TQS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result word dropped while stalled")

  // one command at a time
  `TQS_ASSERT_NEXT(a_one_cmd, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "command taken while busy")

  // only defined event kinds
  `TQS_ASSERT_NOW(a_kind_range, clk_i, rst_ni, !out_valid_i || (out_kind_i <= EV_EXPIRED), "undefined event kind")

  // non-expiry results are single words
  `TQS_ASSERT_NOW(a_single_last, clk_i, rst_ni, !out_valid_i || (out_kind_i == EV_EXPIRED) || out_last_i, "schedule or cancel result without last")

endmodule

bind timer_queue_scheduler tqs_checker u_tqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.event_kind),
  .out_last_i  (out_o.last)
);
